@@ rtl/format_string_tokenizer_assert.svh @@
// Assertion macros used by the format string tokenizer result buffer.
`ifndef FORMAT_STRING_TOKENIZER_ASSERT_SVH
`define FORMAT_STRING_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define FST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define FST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/fst_pkg.sv @@
// Types, constants and character helpers for the format string tokenizer.
package fst_pkg;

  localparam int unsigned MAX_LEN = 65535;
  localparam logic [15:0] POS_LIMIT =
    16'((MAX_LEN < 65535) ? MAX_LEN : 65535);

  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_ELL   = "l";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_SPACE = " ";

  typedef enum logic [2:0] {
    KIND_LIT   = 3'd0,
    KIND_INT   = 3'd1,
    KIND_FLOAT = 3'd2,
    KIND_STR   = 3'd3,
    KIND_PTR   = 3'd4,
    KIND_END   = 3'd5
  } kind_t;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_LIT   = 7'b0000010,
    PH_PCT   = 7'b0000100,
    PH_FLAGS = 7'b0001000,
    PH_WIDTH = 7'b0010000,
    PH_PREC  = 7'b0100000,
    PH_SIZE  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic  is_pct;
    logic  is_flag;
    logic  is_digit;
    logic  is_dot;
    logic  is_ell;
    kind_t kind;
  } char_class_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] total;
    logic        done;
    logic        ovf;
  } piece_t;

  // Up to two results per input beat; the second is only ever the end marker.
  typedef struct packed {
    logic   v0;
    logic   v1;
    piece_t r0;
    piece_t r1;
  } piece_pair_t;

  function automatic kind_t kind_of(input logic [7:0] c);
    kind_t k;
    case (c)
      "d", "i", "c", "C", "u", "x", "X", "o": k = KIND_INT;
      "f", "g", "G", "e", "E":                k = KIND_FLOAT;
      "s":                                    k = KIND_STR;
      "p":                                    k = KIND_PTR;
      default:                                k = KIND_LIT;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/format_string_tokenizer.sv @@
// Top level of the printf-style format string tokenizer.
// The block takes one format character per beat on the input stream and a
// beat with in_tlast set as the end of the string (its data is ignored). Each
// completed piece leaves as one output beat giving start offset, length,
// running piece count and overflow flag in out_tdata and the kind in
// out_tuser; the end of each string yields an end-marker beat with out_tlast
// set that carries the string length and the piece count, after which the
// state is back to its reset values. Characters are accepted one per cycle
// while the output side can take them, each result registered in the output
// register. A terminator that also flushes an open piece produces two beats,
// which the one-entry extra slot behind the output register absorbs; the
// input then waits while the second beat moves into the output register.
// Offsets saturate at 65535 and set the overflow flag.
module format_string_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // terminator
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] piece_start, [31:16] piece_length,
                                  // [47:32] piece_total, [48] overflow, rest zero
  output logic [2:0]  out_tuser,  // [2:0] piece_kind
  output logic        out_tlast   // string_done
);

  logic                 in_fire;
  fst_pkg::char_class_t cls;
  fst_pkg::piece_pair_t res;
  fst_pkg::piece_t      item;

  assign in_fire = in_tvalid && in_tready;

  fst_classify u_classify (
    .ch  (in_tdata),
    .cls (cls)
  );

  fst_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_term (in_tlast),
    .cls     (cls),
    .res     (res)
  );

  fst_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .res        (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (item)
  );

  assign out_tdata = {7'd0, item.ovf, item.total, item.length, item.start};
  assign out_tuser = item.kind;
  assign out_tlast = item.done;

endmodule

@@ rtl/fst_classify.sv @@
// Character classifier: decodes one format character into its token classes.
module fst_classify (
  input  logic [7:0]          ch,
  output fst_pkg::char_class_t cls
);

  always_comb begin
    cls.is_pct   = (ch == fst_pkg::CH_PCT);
    cls.is_flag  = (ch == fst_pkg::CH_MINUS) || (ch == fst_pkg::CH_PLUS) ||
                   (ch == fst_pkg::CH_HASH)  || (ch == fst_pkg::CH_SPACE);
    cls.is_digit = (ch >= fst_pkg::CH_ZERO) && (ch <= fst_pkg::CH_NINE);
    cls.is_dot   = (ch == fst_pkg::CH_DOT);
    cls.is_ell   = (ch == fst_pkg::CH_ELL);
    cls.kind     = fst_pkg::kind_of(ch);
  end

endmodule

@@ rtl/fst_core.sv @@
// Tokenizer state machine: tracks the parse phase and positions, forms pieces.
module fst_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_term,
  input  fst_pkg::char_class_t cls,
  output fst_pkg::piece_pair_t res
);

  fst_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     cs_r, cs_nxt;
  logic [15:0]     pos_r, pos_nxt;
  logic [15:0]     pieces_r, pieces_nxt;
  logic            ovf_r, ovf_nxt;

  logic [15:0] pieces_inc;
  logic        at_limit;
  logic [15:0] off;
  logic [16:0] conv_len_w;
  logic [15:0] conv_len;
  logic        conv;
  logic        pending;

  assign pieces_inc = (pieces_r == 16'hFFFF) ? pieces_r : pieces_r + 16'd1;
  assign at_limit   = (pos_r >= fst_pkg::POS_LIMIT);
  assign off        = at_limit ? fst_pkg::POS_LIMIT : pos_r;
  assign conv_len_w = {1'b0, off} - {1'b0, cs_r} + 17'd1;
  assign conv_len   = (conv_len_w > {1'b0, fst_pkg::POS_LIMIT}) ?
                      fst_pkg::POS_LIMIT : conv_len_w[15:0];

  always_comb begin
    phase_nxt  = phase_r;
    cs_nxt     = cs_r;
    pos_nxt    = pos_r;
    pieces_nxt = pieces_r;
    ovf_nxt    = ovf_r;
    conv       = 1'b0;
    pending    = 1'b0;

    res.v0        = 1'b0;
    res.v1        = 1'b0;
    res.r0.kind   = fst_pkg::KIND_LIT;
    res.r0.start  = '0;
    res.r0.length = '0;
    res.r0.total  = pieces_inc;
    res.r0.done   = 1'b0;
    res.r0.ovf    = ovf_r;
    res.r1.kind   = fst_pkg::KIND_END;
    res.r1.start  = pos_r;
    res.r1.length = '0;
    res.r1.total  = pieces_inc;
    res.r1.done   = 1'b1;
    res.r1.ovf    = ovf_r;

    case (phase_r)
      fst_pkg::PH_LIT, fst_pkg::PH_PCT, fst_pkg::PH_FLAGS, fst_pkg::PH_WIDTH,
      fst_pkg::PH_PREC, fst_pkg::PH_SIZE: pending = 1'b1;
      default:                            pending = 1'b0;
    endcase

    if (in_fire && in_term) begin
      // Flush whatever is open, or the empty literal of an empty string.
      if (pending || (pieces_r == 16'd0)) begin
        res.v0        = 1'b1;
        res.v1        = 1'b1;
        res.r0.start  = pending ? cs_r : pos_r;
        res.r0.length = pending ? (pos_r - cs_r) : 16'd0;
      end else begin
        res.v0        = 1'b1;
        res.r0.kind   = fst_pkg::KIND_END;
        res.r0.start  = pos_r;
        res.r0.total  = pieces_r;
        res.r0.done   = 1'b1;
      end
      phase_nxt  = fst_pkg::PH_IDLE;
      cs_nxt     = '0;
      pos_nxt    = '0;
      pieces_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (in_fire) begin
      ovf_nxt    = ovf_r | at_limit;
      pos_nxt    = at_limit ? fst_pkg::POS_LIMIT : pos_r + 16'd1;
      res.r0.ovf = ovf_r | at_limit;
      case (phase_r)
        fst_pkg::PH_LIT: begin
          if (cls.is_pct) begin
            res.v0        = 1'b1;
            res.r0.start  = cs_r;
            res.r0.length = off - cs_r;
            pieces_nxt    = pieces_inc;
            cs_nxt        = off;
            phase_nxt     = fst_pkg::PH_PCT;
          end
        end
        fst_pkg::PH_PCT: begin
          if (cls.is_pct) begin
            res.v0        = 1'b1;
            res.r0.start  = cs_r;
            res.r0.length = 16'd1;
            pieces_nxt    = pieces_inc;
            phase_nxt     = fst_pkg::PH_IDLE;
          end else if (cls.is_flag) begin
            phase_nxt = fst_pkg::PH_FLAGS;
          end else if (cls.is_digit) begin
            phase_nxt = fst_pkg::PH_WIDTH;
          end else if (cls.is_dot) begin
            phase_nxt = fst_pkg::PH_PREC;
          end else if (cls.is_ell) begin
            phase_nxt = fst_pkg::PH_SIZE;
          end else begin
            conv = 1'b1;
          end
        end
        fst_pkg::PH_FLAGS: begin
          if (cls.is_flag) begin
            phase_nxt = fst_pkg::PH_FLAGS;
          end else if (cls.is_digit) begin
            phase_nxt = fst_pkg::PH_WIDTH;
          end else if (cls.is_dot) begin
            phase_nxt = fst_pkg::PH_PREC;
          end else if (cls.is_ell) begin
            phase_nxt = fst_pkg::PH_SIZE;
          end else begin
            conv = 1'b1;
          end
        end
        fst_pkg::PH_WIDTH: begin
          if (cls.is_digit) begin
            phase_nxt = fst_pkg::PH_WIDTH;
          end else if (cls.is_dot) begin
            phase_nxt = fst_pkg::PH_PREC;
          end else if (cls.is_ell) begin
            phase_nxt = fst_pkg::PH_SIZE;
          end else begin
            conv = 1'b1;
          end
        end
        fst_pkg::PH_PREC: begin
          if (cls.is_digit) begin
            phase_nxt = fst_pkg::PH_PREC;
          end else if (cls.is_ell) begin
            phase_nxt = fst_pkg::PH_SIZE;
          end else begin
            conv = 1'b1;
          end
        end
        fst_pkg::PH_SIZE: begin
          conv = 1'b1;
        end
        default: begin
          // Between pieces; an illegal phase code is handled the same way.
          cs_nxt    = off;
          phase_nxt = cls.is_pct ? fst_pkg::PH_PCT : fst_pkg::PH_LIT;
        end
      endcase

      if (conv) begin
        res.v0        = 1'b1;
        res.r0.kind   = cls.kind;
        res.r0.start  = cs_r;
        res.r0.length = conv_len;
        pieces_nxt    = pieces_inc;
        phase_nxt     = fst_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fst_pkg::PH_IDLE;
      cs_r     <= '0;
      pos_r    <= '0;
      pieces_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cs_r     <= cs_nxt;
      pos_r    <= pos_nxt;
      pieces_r <= pieces_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

@@ rtl/fst_outbuf.sv @@
// Result buffer: an output register plus one extra slot for the end marker.
`include "format_string_tokenizer_assert.svh"

module fst_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fst_pkg::piece_pair_t res,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fst_pkg::piece_t      out_item
);

  logic            a_valid_r, a_valid_nxt;
  logic            b_valid_r, b_valid_nxt;
  fst_pkg::piece_t a_r, a_nxt;
  fst_pkg::piece_t b_r, b_nxt;

  // A new beat is taken only when the extra slot is free and the output
  // register is empty or empties in this cycle, so two results always fit.
  assign can_accept = !b_valid_r && (!a_valid_r || out_ready);
  assign out_valid  = a_valid_r;
  assign out_item   = a_r;

  always_comb begin
    a_valid_nxt = a_valid_r;
    b_valid_nxt = b_valid_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    if (push) begin
      a_valid_nxt = res.v0;
      b_valid_nxt = res.v1;
      a_nxt       = res.r0;
      b_nxt       = res.r1;
    end else if (a_valid_r && out_ready) begin
      a_valid_nxt = b_valid_r;
      a_nxt       = b_r;
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  `FST_ASSERT_IMPLIES(a_extra_needs_head, clk, rst_n, b_valid_r, a_valid_r, "extra slot filled while output register is empty")
  `FST_ASSERT_IMPLIES(a_extra_is_end, clk, rst_n, b_valid_r, b_r.done && (b_r.kind == fst_pkg::KIND_END), "extra slot holds something other than an end marker")
  `FST_ASSERT_IMPLIES(a_end_zero_len, clk, rst_n, a_valid_r && a_r.done, a_r.length == 16'd0, "end marker with nonzero length")
  `FST_ASSERT_NEXT(a_pair_lands, clk, rst_n, push && res.v1, a_valid_r && b_valid_r, "two results of one beat not both buffered")

endmodule
